>>> hw/rtl/cfm_pkg.sv
// Shared constants, types and state codes of the capture frequency meter.
`timescale 1ns / 1ps

package cfm_pkg;

  // Free-running counter and overflow counter widths.
  localparam int CNT_W  = 16;
  localparam int OVF_W  = 16;
  localparam int ELAP_W = OVF_W + CNT_W;

  // Result word width, divisor register width and division widths.
  localparam int DATA_W = 32;
  localparam int DIV_W  = 17;
  localparam int DEN_W  = DATA_W + DIV_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int STEP_W = $clog2(DATA_W);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Saturation value of the overflow count.
  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  // Register file: two words, selected by address bit 2.
  localparam int ADDR_W = 3;
  localparam logic REG_CLOCK   = 1'b0;
  localparam logic REG_DIVISOR = 1'b1;
  localparam logic [DATA_W-1:0] CLOCK_RESET   = 32'd84000000;
  localparam logic [DIV_W-1:0]  DIVISOR_RESET = 17'd100;

  // One finished interval handed from the front to the back.
  typedef struct packed {
    logic [DATA_W-1:0] ticks;
    logic              force_zero;
    logic              saturated;
    logic              zero;
  } cfm_job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } cfm_qstat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } cfm_back_state_t;

endpackage

>>> hw/rtl/cfm_front.sv
// Front end: accepts events, tracks the armed state and overflow count, forms intervals.
`timescale 1ns / 1ps

module cfm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic                        overflow_event,
  input  logic                        capture_event,
  input  logic [15:0]                 capture_value,
  input  cfm_pkg::cfm_qstat_t         qstat,
  output logic                        push,
  output cfm_pkg::cfm_job_t           push_job
);

  logic                          armed;
  logic [cfm_pkg::CNT_W-1:0]     first_capture;
  logic [cfm_pkg::OVF_W-1:0]     overflow_count;
  logic                          saturated_mark;

  logic                          fire;
  logic [cfm_pkg::CNT_W-1:0]     val;
  logic [cfm_pkg::OVF_W-1:0]     overflow_count_next;
  logic                          saturated_mark_next;
  logic [cfm_pkg::OVF_W-1:0]     high_part;
  logic [cfm_pkg::ELAP_W-1:0]    elapsed;
  logic                          too_long;

  // Items are taken whenever the queue has room for a result.
  assign s_tready = !qstat.full;
  assign fire     = s_tvalid && s_tready;
  assign val      = capture_value[cfm_pkg::CNT_W-1:0];

  // Overflow is applied before the capture of the same item.
  always_comb begin
    overflow_count_next = overflow_count;
    saturated_mark_next = saturated_mark;
    if (overflow_event && armed) begin
      if (overflow_count < cfm_pkg::OVF_MAX) begin
        overflow_count_next = overflow_count + 1'b1;
      end
      if (overflow_count_next == cfm_pkg::OVF_MAX) begin
        saturated_mark_next = 1'b1;
      end
    end
  end

  // Interval: a backward second capture with no overflow counts one full wrap.
  always_comb begin
    if ((overflow_count_next == '0) && (val < first_capture)) begin
      high_part = cfm_pkg::OVF_W'(1);
    end else begin
      high_part = overflow_count_next;
    end
    elapsed  = {high_part, val} - cfm_pkg::ELAP_W'(first_capture);
    too_long = |(elapsed >> cfm_pkg::DATA_W);
  end

  // A second capture hands the interval to the back end.
  always_comb begin
    push                = fire && capture_event && armed;
    push_job.ticks      = too_long ? '1 : cfm_pkg::DATA_W'(elapsed);
    push_job.zero       = (elapsed == '0);
    push_job.force_zero = (elapsed == '0) || too_long;
    push_job.saturated  = saturated_mark_next;
  end

  // Measurement state.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      first_capture  <= '0;
      overflow_count <= '0;
      saturated_mark <= 1'b0;
    end else if (fire) begin
      if (capture_event) begin
        if (!armed) begin
          first_capture <= val;
          armed         <= 1'b1;
        end else begin
          armed <= 1'b0;
        end
        overflow_count <= '0;
        saturated_mark <= 1'b0;
      end else begin
        overflow_count <= overflow_count_next;
        saturated_mark <= saturated_mark_next;
      end
    end
  end

endmodule

>>> hw/rtl/cfm_queue.sv
// Small queue of finished intervals between the front end and the back end.
`timescale 1ns / 1ps

module cfm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cfm_pkg::cfm_job_t    push_job,
  input  logic                 pop,
  output cfm_pkg::cfm_job_t    pop_job,
  output cfm_pkg::cfm_qstat_t  qstat
);

  cfm_pkg::cfm_job_t             slots [cfm_pkg::QUEUE_DEPTH];
  logic [cfm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [cfm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [cfm_pkg::QCNT_W-1:0]    fill;

  assign qstat.full  = (fill == cfm_pkg::QCNT_W'(cfm_pkg::QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign pop_job     = slots[rd_ptr];

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cfm_pkg::QPTR_W'(cfm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cfm_pkg::QPTR_W'(cfm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/cfm_back.sv
// Back end: multiplies the interval by the prescale, divides the clock and holds the result.
`timescale 1ns / 1ps

module cfm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  cfm_pkg::cfm_qstat_t           qstat,
  input  cfm_pkg::cfm_job_t             pop_job,
  output logic                          pop,
  input  logic [cfm_pkg::DATA_W-1:0]    reference_clock_hz,
  input  logic [cfm_pkg::DIV_W-1:0]     tick_divisor,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cfm_pkg::DATA_W-1:0]    frequency,
  output logic [cfm_pkg::DATA_W-1:0]    elapsed_ticks,
  output logic                          overflow_saturated,
  output logic                          zero_interval
);

  cfm_pkg::cfm_back_state_t      state;
  cfm_pkg::cfm_back_state_t      state_next;

  cfm_pkg::cfm_job_t             job;
  logic [cfm_pkg::DEN_W-1:0]     denom;
  logic [cfm_pkg::REM_W-1:0]     rem;
  logic [cfm_pkg::DATA_W-1:0]    dividend;
  logic [cfm_pkg::DATA_W-1:0]    quotient;
  logic [cfm_pkg::STEP_W-1:0]    step;

  logic                          mul_en;
  logic                          div_en;
  logic [cfm_pkg::DIV_W-1:0]     divisor_eff;
  logic [cfm_pkg::REM_W-1:0]     trial;
  logic                          last_step;

  assign last_step   = (step == cfm_pkg::STEP_W'(cfm_pkg::DATA_W - 1));
  assign divisor_eff = (tick_divisor == '0) ? cfm_pkg::DIV_W'(1) : tick_divisor;
  assign trial       = {rem[cfm_pkg::REM_W-2:0], dividend[cfm_pkg::DATA_W-1]};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cfm_pkg::BK_IDLE: begin
        if (!qstat.empty) begin
          state_next = cfm_pkg::BK_MUL;
        end
      end
      cfm_pkg::BK_MUL: begin
        state_next = cfm_pkg::BK_DIV;
      end
      cfm_pkg::BK_DIV: begin
        if (last_step) begin
          state_next = cfm_pkg::BK_OUT;
        end
      end
      cfm_pkg::BK_OUT: begin
        if (m_tready) begin
          state_next = cfm_pkg::BK_IDLE;
        end
      end
      default: state_next = cfm_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop      = 1'b0;
    mul_en   = 1'b0;
    div_en   = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      cfm_pkg::BK_IDLE: pop      = !qstat.empty;
      cfm_pkg::BK_MUL:  mul_en   = 1'b1;
      cfm_pkg::BK_DIV:  div_en   = 1'b1;
      cfm_pkg::BK_OUT:  m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load, multiply, then one restoring division step per cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
    if (mul_en) begin
      denom    <= cfm_pkg::DEN_W'(job.ticks * divisor_eff);
      dividend <= reference_clock_hz;
      rem      <= '0;
      quotient <= '0;
      step     <= '0;
    end
    if (div_en) begin
      dividend <= {dividend[cfm_pkg::DATA_W-2:0], 1'b0};
      step     <= step + 1'b1;
      if (trial >= {1'b0, denom}) begin
        rem      <= trial - {1'b0, denom};
        quotient <= {quotient[cfm_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem      <= trial;
        quotient <= {quotient[cfm_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  assign frequency          = job.force_zero ? '0 : quotient;
  assign elapsed_ticks      = job.ticks;
  assign overflow_saturated = job.saturated;
  assign zero_interval      = job.zero;

endmodule

>>> hw/rtl/capture_frequency_meter_unit.sv
// Top level of the capture frequency meter: register file, front end, queue and back end.
`timescale 1ns / 1ps

// Input capture frequency meter.
// Input stream (s_*): one transfer per timer event; s_tuser carries the overflow and
// capture flags, s_tdata the latched counter value. Overflows count only while armed.
// The first capture arms the meter; the second one completes an interval and yields
// one result on the output stream (m_*), carrying frequency and elapsed ticks in
// m_tdata and the saturation and zero-interval flags in m_tuser. Other items give none.
// A completing capture is written into the queue, loaded by the back end, and its
// interval is multiplied by the prescale; the reference clock is then divided by the
// product in a restoring division, one quotient bit per cycle. The back end takes the
// next interval only once the last result has been accepted, but items that give no
// result are taken one per cycle while the two-entry queue has room.
// When the output is stalled the result holds; the front end keeps taking items until
// the queue is full, then drops s_tready.
// Reset (rst, synchronous) disarms the meter, empties the queue and loads the
// registers with 84000000 Hz and a prescale of 100. Registers are written over the
// APB port at byte addresses 0 and 4 and are read back there.

module capture_frequency_meter_unit (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfm_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] capture_value
  input  logic [1:0]                    s_tuser,   // [0] overflow_event, [1] capture_event
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // [31:0] frequency, [63:32] elapsed_ticks
  output logic [1:0]                    m_tuser    // [0] overflow_saturated, [1] zero_interval
);

  logic [cfm_pkg::DATA_W-1:0] reference_clock_hz;
  logic [cfm_pkg::DIV_W-1:0]  tick_divisor;
  logic                       reg_sel;
  logic                       cfg_write;

  cfm_pkg::cfm_qstat_t        qstat;
  cfm_pkg::cfm_job_t          push_job;
  cfm_pkg::cfm_job_t          pop_job;
  logic                       push;
  logic                       pop;

  logic [cfm_pkg::DATA_W-1:0] frequency;
  logic [cfm_pkg::DATA_W-1:0] elapsed_ticks;
  logic                       overflow_saturated;
  logic                       zero_interval;

  // Register file.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[cfm_pkg::ADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_clock_hz <= cfm_pkg::CLOCK_RESET;
      tick_divisor       <= cfm_pkg::DIVISOR_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        cfm_pkg::REG_CLOCK:   reference_clock_hz <= pwdata;
        cfm_pkg::REG_DIVISOR: tick_divisor       <= pwdata[cfm_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cfm_pkg::REG_CLOCK:   prdata = reference_clock_hz;
      cfm_pkg::REG_DIVISOR: prdata = 32'(tick_divisor);
      default:              prdata = '0;
    endcase
  end

  cfm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .overflow_event (s_tuser[0]),
    .capture_event  (s_tuser[1]),
    .capture_value  (s_tdata),
    .qstat          (qstat),
    .push           (push),
    .push_job       (push_job)
  );

  cfm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  cfm_back u_back (
    .clk                (clk),
    .rst                (rst),
    .qstat              (qstat),
    .pop_job            (pop_job),
    .pop                (pop),
    .reference_clock_hz (reference_clock_hz),
    .tick_divisor       (tick_divisor),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .frequency          (frequency),
    .elapsed_ticks      (elapsed_ticks),
    .overflow_saturated (overflow_saturated),
    .zero_interval      (zero_interval)
  );

  assign m_tdata = {elapsed_ticks, frequency};
  assign m_tuser = {zero_interval, overflow_saturated};

  // A zero interval always reports a zero frequency.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[31:0] == '0))
    else $error("zero interval with nonzero frequency");

  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("interval pushed into a full queue");

  // The back end only takes an interval that is there.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("interval popped from an empty queue");

  // An interval pushed into an empty queue is taken up on the next cycle when the back end idles.
  assert property (@(posedge clk) disable iff (rst)
    (push && qstat.empty && !m_tvalid && !pop && (u_back.state == cfm_pkg::BK_IDLE))
      |=> pop)
    else $error("idle back end did not take a waiting interval");

endmodule
